// ----- hdl/ffac_pkg.sv -----
// shared constants, codes and controller/datapath types for the first-fit allocator
`timescale 1ns / 1ps
package ffac_pkg;
   localparam int PAGE_BYTES  = 4096;
   localparam int UNIT_BYTES  = 8;
   localparam int NUM_UNITS   = PAGE_BYTES / UNIT_BYTES;
   localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
   localparam int IDX_W       = $clog2(NUM_UNITS);
   localparam int LEN_W       = IDX_W + 1;
   localparam int SIZE_W      = 13;
   localparam int OFFS_W      = 12;
   localparam int SCAN_LANES  = 8;
   localparam int LANE_W      = $clog2(SCAN_LANES);
   localparam int SCAN_STEPS  = NUM_UNITS / SCAN_LANES;
   localparam int STEP_W      = $clog2(SCAN_STEPS);
   localparam int MARK_BITS   = 64;
   localparam int MBIT_W      = $clog2(MARK_BITS);
   localparam int MARK_WORDS  = NUM_UNITS / MARK_BITS;
   localparam int WORD_W      = $clog2(MARK_WORDS);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_SIZE  = 2'd1,
      ST_NO_SPACE  = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef struct packed {
      logic       clear_step;
      logic       load;
      logic       scan_step;
      logic       free_place;
      logic       alloc_place;
      logic       mark_step;
      logic       set_code;
      status_type code;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_is_free;
      logic req_bad_size;
      logic req_bad_offset;
      logic len_zero;
      logic scan_hit;
      logic scan_last;
      logic mark_last;
      logic rsp_busy;
   } sts_type;
endpackage

// ----- hdl/ffac_datapath.sv -----
// free map, block length memory, run scanner, range marker and result register
`timescale 1ns / 1ps
module ffac_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  ffac_pkg::cmd_type            cmd,
   output ffac_pkg::sts_type            sts,
   input  logic                         req_operation,
   input  logic [ffac_pkg::SIZE_W-1:0]  req_size_bytes,
   input  logic [ffac_pkg::OFFS_W-1:0]  req_block_offset,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [ffac_pkg::OFFS_W-1:0]  rsp_result_offset
);
   logic [ffac_pkg::NUM_UNITS-1:0] free_map_ff, free_map_in;
   logic [ffac_pkg::LEN_W-1:0]     len_mem [ffac_pkg::NUM_UNITS];
   logic [ffac_pkg::LEN_W-1:0]     len_rd_ff;
   logic [ffac_pkg::IDX_W-1:0]     clr_ff;
   logic [ffac_pkg::LEN_W-1:0]     need_ff;
   logic [ffac_pkg::IDX_W-1:0]     idx_ff;
   logic [ffac_pkg::STEP_W-1:0]    scan_ff;
   logic [ffac_pkg::LEN_W-1:0]     run_len_ff, run_len_v;
   logic [ffac_pkg::IDX_W-1:0]     run_start_ff, run_start_v;
   logic [ffac_pkg::IDX_W-1:0]     hit_start_ff, hit_start_v;
   logic [ffac_pkg::LEN_W-1:0]     hit_len_ff, hit_len_v;
   logic                           hit_v;
   logic [ffac_pkg::SCAN_LANES-1:0] chunk;
   logic [ffac_pkg::IDX_W-1:0]     unit_v;
   logic [ffac_pkg::LEN_W-1:0]     first_sum;
   logic [ffac_pkg::IDX_W-1:0]     first;
   logic [ffac_pkg::IDX_W-1:0]     lo_ff;
   logic [ffac_pkg::LEN_W-1:0]     hi_ff;
   logic                           mark_val_ff;
   logic [ffac_pkg::WORD_W-1:0]    word_ff;
   logic [ffac_pkg::MARK_BITS-1:0] word_v;
   logic [ffac_pkg::LEN_W-1:0]     mu_v;
   logic                           mem_we;
   logic [ffac_pkg::IDX_W-1:0]     mem_wa;
   logic [ffac_pkg::LEN_W-1:0]     mem_wd;
   ffac_pkg::status_type           code_ff;
   logic [ffac_pkg::OFFS_W-1:0]    res_offset_ff;
   logic                           rsp_valid_ff;
   ffac_pkg::status_type           rsp_status_ff;
   logic [ffac_pkg::OFFS_W-1:0]    rsp_offset_ff;

   function automatic logic [ffac_pkg::LEN_W-1:0] LEN_W_ADD(
      input logic [ffac_pkg::IDX_W-1:0] a,
      input logic [ffac_pkg::LEN_W-1:0] b
   );
      LEN_W_ADD = {1'b0, a} + b;
   endfunction

   // request decode
   assign sts.req_is_free    = (req_operation == ffac_pkg::OP_FREE);
   assign sts.req_bad_size   = (req_size_bytes == '0) ||
                               (req_size_bytes[ffac_pkg::UNIT_SHIFT-1:0] != '0);
   assign sts.req_bad_offset = (req_block_offset[ffac_pkg::UNIT_SHIFT-1:0] != '0);
   assign sts.len_zero       = (len_rd_ff == '0);
   assign sts.clear_last     = (clr_ff == ffac_pkg::IDX_W'(ffac_pkg::NUM_UNITS - 1));
   assign sts.scan_last      = (scan_ff == ffac_pkg::STEP_W'(ffac_pkg::SCAN_STEPS - 1));
   assign sts.mark_last      = (word_ff == ffac_pkg::WORD_W'(ffac_pkg::MARK_WORDS - 1));
   assign sts.rsp_busy       = rsp_valid_ff && !rsp_ready;
   assign sts.scan_hit       = hit_v;

   // run scan over one chunk of lanes
   always_comb begin
      chunk = free_map_ff[{scan_ff, {ffac_pkg::LANE_W{1'b0}}} +: ffac_pkg::SCAN_LANES];
      run_len_v   = run_len_ff;
      run_start_v = run_start_ff;
      hit_v       = 1'b0;
      hit_start_v = run_start_ff;
      hit_len_v   = run_len_ff;
      unit_v      = '0;
      for (int k = 0; k < ffac_pkg::SCAN_LANES; k++) begin
         unit_v = {scan_ff, ffac_pkg::LANE_W'(k)};
         if (!hit_v) begin
            if (chunk[k]) begin
               if (run_len_v == '0) begin
                  run_start_v = unit_v;
               end
               run_len_v = run_len_v + 1'b1;
            end else begin
               if (run_len_v >= need_ff) begin
                  hit_v       = 1'b1;
                  hit_start_v = run_start_v;
                  hit_len_v   = run_len_v;
               end
               run_len_v = '0;
            end
         end
      end
      // run that reaches the end of the page
      if (!hit_v && sts.scan_last && run_len_v >= need_ff) begin
         hit_v       = 1'b1;
         hit_start_v = run_start_v;
         hit_len_v   = run_len_v;
      end
   end

   // top end of the chosen run
   assign first_sum = LEN_W_ADD(hit_start_ff, hit_len_ff) - need_ff;
   assign first     = first_sum[ffac_pkg::IDX_W-1:0];

   // range marker, one word per cycle
   always_comb begin
      free_map_in = free_map_ff;
      word_v = free_map_ff[{word_ff, {ffac_pkg::MBIT_W{1'b0}}} +: ffac_pkg::MARK_BITS];
      mu_v   = '0;
      for (int b = 0; b < ffac_pkg::MARK_BITS; b++) begin
         mu_v = {1'b0, word_ff, ffac_pkg::MBIT_W'(b)};
         if (mu_v >= {1'b0, lo_ff} && mu_v < hi_ff) begin
            word_v[b] = mark_val_ff;
         end
      end
      free_map_in[{word_ff, {ffac_pkg::MBIT_W{1'b0}}} +: ffac_pkg::MARK_BITS] = word_v;
   end

   // memory write port
   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_ff;
      mem_wd = '0;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.free_place) begin
         mem_we = 1'b1;
         mem_wa = idx_ff;
      end else if (cmd.alloc_place) begin
         mem_we = 1'b1;
         mem_wa = first;
         mem_wd = need_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         len_mem[mem_wa] <= mem_wd;
      end
      if (cmd.load) begin
         len_rd_ff <= len_mem[req_block_offset[ffac_pkg::OFFS_W-1:ffac_pkg::UNIT_SHIFT]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff  <= '1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.mark_step) begin
            free_map_ff <= free_map_in;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         need_ff       <= req_size_bytes[ffac_pkg::SIZE_W-1:ffac_pkg::UNIT_SHIFT];
         idx_ff        <= req_block_offset[ffac_pkg::OFFS_W-1:ffac_pkg::UNIT_SHIFT];
         scan_ff       <= '0;
         run_len_ff    <= '0;
         run_start_ff  <= '0;
         res_offset_ff <= '0;
      end
      if (cmd.scan_step) begin
         scan_ff      <= scan_ff + 1'b1;
         run_len_ff   <= run_len_v;
         run_start_ff <= run_start_v;
         hit_start_ff <= hit_start_v;
         hit_len_ff   <= hit_len_v;
      end
      if (cmd.free_place) begin
         lo_ff       <= idx_ff;
         hi_ff       <= LEN_W_ADD(idx_ff, len_rd_ff);
         mark_val_ff <= 1'b1;
         word_ff     <= '0;
      end else if (cmd.alloc_place) begin
         lo_ff         <= first;
         hi_ff         <= LEN_W_ADD(first, need_ff);
         mark_val_ff   <= 1'b0;
         word_ff       <= '0;
         res_offset_ff <= {first, {ffac_pkg::UNIT_SHIFT{1'b0}}};
      end else if (cmd.mark_step) begin
         word_ff <= word_ff + 1'b1;
      end
      if (cmd.set_code) begin
         code_ff <= cmd.code;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= code_ff;
         rsp_offset_ff <= (code_ff == ffac_pkg::ST_OK) ? res_offset_ff : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_offset = rsp_offset_ff;
endmodule

// ----- hdl/ffac_control.sv -----
// request sequencer for the first-fit allocator
`timescale 1ns / 1ps
module ffac_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffac_pkg::sts_type sts,
   output ffac_pkg::cmd_type cmd
);
   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_RDLEN = 8'b0000_0100,
      S_SCAN  = 8'b0000_1000,
      S_PLACE = 8'b0001_0000,
      S_MARK  = 8'b0010_0000,
      S_RESP  = 8'b0100_0000,
      S_HOLD  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ffac_pkg::ST_OK;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (sts.req_is_free) begin
                  if (sts.req_bad_offset) begin
                     cmd.set_code = 1'b1;
                     cmd.code     = ffac_pkg::ST_NOT_ALLOC;
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_RDLEN;
                  end
               end else if (sts.req_bad_size) begin
                  cmd.set_code = 1'b1;
                  cmd.code     = ffac_pkg::ST_BAD_SIZE;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_RDLEN: begin
            if (sts.len_zero) begin
               cmd.set_code = 1'b1;
               cmd.code     = ffac_pkg::ST_NOT_ALLOC;
               state_in     = S_RESP;
            end else begin
               cmd.free_place = 1'b1;
               state_in       = S_MARK;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit) begin
               state_in = S_PLACE;
            end else if (sts.scan_last) begin
               cmd.set_code = 1'b1;
               cmd.code     = ffac_pkg::ST_NO_SPACE;
               state_in     = S_RESP;
            end
         end
         S_PLACE: begin
            cmd.alloc_place = 1'b1;
            state_in        = S_MARK;
         end
         S_MARK: begin
            cmd.mark_step = 1'b1;
            if (sts.mark_last) begin
               cmd.set_code = 1'b1;
               cmd.code     = ffac_pkg::ST_OK;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            // output slot still full, wait for it to drain
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_hit_places: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && sts.scan_hit) |=> (state_ff == S_PLACE))
      else $error("scan hit not followed by placement");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !sts.rsp_busy)
      else $error("result loaded over a pending result");

   a_mark_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK && !sts.mark_last) |=> (state_ff == S_MARK))
      else $error("mark sweep cut short");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request accepted during memory clear");
endmodule

// ----- hdl/first_fit_allocator_coalescing.sv -----
// top level of the first-fit page allocator with coalescing
`timescale 1ns / 1ps
// First-fit allocator for one 4096-byte page in 8-byte units. After reset the
// block clears its block length memory, one entry a cycle, before req_ready
// rises. An allocate scans the free map 8 units per cycle, stopping at the
// first run that fits, then places the block, marks the 512-unit map one
// 64-bit word at a time and loads the result; an allocate that finds no space
// loads its result once the scan reaches the end of the page. A free reads the
// block length memory, runs the same mark sweep and loads the result; a free
// of an unallocated block stops after the memory read and other rejected
// requests go straight to loading their result. req_ready rises the cycle
// after the result is loaded. The result sits in an output register, so a new
// request is taken while the previous result waits for rsp_ready; the next
// result then waits until that register drains.
module first_fit_allocator_coalescing (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic [ffac_pkg::SIZE_W-1:0] req_size_bytes,
   input  logic [ffac_pkg::OFFS_W-1:0] req_block_offset,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [ffac_pkg::OFFS_W-1:0] rsp_result_offset
);
   ffac_pkg::cmd_type cmd;
   ffac_pkg::sts_type sts;

   ffac_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffac_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_size_bytes    (req_size_bytes),
      .req_block_offset  (req_block_offset),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_offset (rsp_result_offset)
   );
endmodule

// ----- tb/first_fit_allocator_coalescing_checker.sv -----
// checker for the first-fit allocator: tracks the free map and compares every response
`timescale 1ns / 1ps
module first_fit_allocator_coalescing_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_operation,
   input  logic [ffac_pkg::SIZE_W-1:0] req_size_bytes,
   input  logic [ffac_pkg::OFFS_W-1:0] req_block_offset,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [1:0]                  rsp_status,
   input  logic [ffac_pkg::OFFS_W-1:0] rsp_result_offset,
   output int                          fail_count,
   output int                          pending_count
);
   typedef struct packed {
      ffac_pkg::status_type          status;
      logic [ffac_pkg::OFFS_W-1:0]   offset;
   } alloc_result_type;

   logic                         unit_free [ffac_pkg::NUM_UNITS];
   logic [ffac_pkg::LEN_W-1:0]   block_len [ffac_pkg::NUM_UNITS];
   alloc_result_type             expected_q[$];

   function automatic alloc_result_type predict_alloc(
      input logic [ffac_pkg::SIZE_W-1:0] size);
      alloc_result_type r;
      int need, run_start, run_len, first;
      r = '{ffac_pkg::ST_NO_SPACE, '0};
      run_start = 0;
      run_len = 0;
      if (size == 0 || size % ffac_pkg::UNIT_BYTES != 0)
         return '{ffac_pkg::ST_BAD_SIZE, '0};
      need = size / ffac_pkg::UNIT_BYTES;
      if (need > ffac_pkg::NUM_UNITS) return r;
      for (int i = 0; i <= ffac_pkg::NUM_UNITS; i++) begin
         if (i < ffac_pkg::NUM_UNITS && unit_free[i]) begin
            if (run_len == 0) run_start = i;
            run_len++;
         end else begin
            if (run_len >= need) begin
               // top end of the first run that fits
               first = run_start + run_len - need;
               for (int k = first; k < first + need; k++) unit_free[k] = 1'b0;
               block_len[first] = ffac_pkg::LEN_W'(need);
               return '{ffac_pkg::ST_OK,
                        ffac_pkg::OFFS_W'(first * ffac_pkg::UNIT_BYTES)};
            end
            run_len = 0;
         end
      end
      return r;
   endfunction

   function automatic alloc_result_type predict_free(
      input logic [ffac_pkg::OFFS_W-1:0] offs);
      int idx, len;
      if (offs % ffac_pkg::UNIT_BYTES != 0) return '{ffac_pkg::ST_NOT_ALLOC, '0};
      idx = offs / ffac_pkg::UNIT_BYTES;
      if (idx >= ffac_pkg::NUM_UNITS || block_len[idx] == 0)
         return '{ffac_pkg::ST_NOT_ALLOC, '0};
      len = block_len[idx];
      block_len[idx] = '0;
      for (int k = idx; k < idx + len && k < ffac_pkg::NUM_UNITS; k++) unit_free[k] = 1'b1;
      return '{ffac_pkg::ST_OK, '0};
   endfunction

   always @(posedge clock) begin
      alloc_result_type exp_r;
      int errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < ffac_pkg::NUM_UNITS; i++) begin
            unit_free[i] = 1'b1;
            block_len[i] = '0;
         end
         expected_q.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding");
               errs++;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_status != exp_r.status) begin
                  $error("status: expected %0d, got %0d", exp_r.status, rsp_status);
                  errs++;
               end
               if (rsp_result_offset != exp_r.offset) begin
                  $error("result_offset: expected %0d, got %0d", exp_r.offset,
                         rsp_result_offset);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_operation == ffac_pkg::OP_ALLOC)
               expected_q.push_back(predict_alloc(req_size_bytes));
            else
               expected_q.push_back(predict_free(req_block_offset));
         end
         fail_count    <= fail_count + errs;
         pending_count <= expected_q.size();
      end
   end
endmodule

// ----- tb/first_fit_allocator_coalescing_tb.sv -----
// top of the first-fit allocator testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module first_fit_allocator_coalescing_tb;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_operation = ffac_pkg::OP_ALLOC;
   logic [ffac_pkg::SIZE_W-1:0] req_size_bytes = '0;
   logic [ffac_pkg::OFFS_W-1:0] req_block_offset = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [1:0]                  rsp_status;
   logic [ffac_pkg::OFFS_W-1:0] rsp_result_offset;
   int                          fail_count;
   int                          pending_count;
   int                          send_idle_pct = 31;
   int                          recv_idle_pct = 75;
   int                          quiet_cycles = 0;
   logic [ffac_pkg::OFFS_W-1:0] live_offsets[$];

   first_fit_allocator_coalescing u_top (.*);

   first_fit_allocator_coalescing_checker u_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // remember handed-out offsets so frees often hit a live block
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_status == ffac_pkg::ST_OK &&
          rsp_result_offset != '0) begin
         live_offsets.push_back(rsp_result_offset);
      end
   end

   // watchdog on cycles where nothing is accepted
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else if (!reset) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_request(input logic op, input logic [ffac_pkg::SIZE_W-1:0] size,
                               input logic [ffac_pkg::OFFS_W-1:0] offs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_size_bytes   <= size;
      req_block_offset <= offs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      int pick;
      logic [ffac_pkg::SIZE_W-1:0] size;
      logic [ffac_pkg::OFFS_W-1:0] offs;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            // mostly small unit-aligned sizes, a few large or malformed
            if ($urandom_range(19) == 0) size = ffac_pkg::SIZE_W'($urandom);
            else size = ffac_pkg::SIZE_W'($urandom_range(1, 40) * ffac_pkg::UNIT_BYTES);
            send_request(ffac_pkg::OP_ALLOC, size, ffac_pkg::OFFS_W'($urandom));
         end else if (pick < 90) begin
            if (live_offsets.size() != 0 && $urandom_range(1) == 1) begin
               offs = live_offsets.pop_front();
            end else begin
               // aligned offset, often in the upper part where blocks tend to sit
               offs = ffac_pkg::OFFS_W'($urandom_range(0, ffac_pkg::NUM_UNITS - 1) *
                                        ffac_pkg::UNIT_BYTES);
               if ($urandom_range(1)) offs = offs | 12'hc00;
            end
            send_request(ffac_pkg::OP_FREE, ffac_pkg::SIZE_W'($urandom), offs);
         end else begin
            send_request(ffac_pkg::OP_FREE, ffac_pkg::SIZE_W'($urandom),
                         ffac_pkg::OFFS_W'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: malformed sizes, extremes, frees of unallocated blocks
      send_request(ffac_pkg::OP_ALLOC, 13'd0, 12'hfff);
      send_request(ffac_pkg::OP_ALLOC, 13'd7, 12'd0);
      send_request(ffac_pkg::OP_ALLOC, 13'h1fff, 12'd0);
      send_request(ffac_pkg::OP_ALLOC, 13'd4104, 12'd0);
      send_request(ffac_pkg::OP_FREE, 13'h1fff, 12'd0);
      send_request(ffac_pkg::OP_FREE, 13'd0, 12'd3);
      send_request(ffac_pkg::OP_FREE, 13'd0, 12'hfff);
      send_request(ffac_pkg::OP_ALLOC, 13'd4096, 12'd0);
      send_request(ffac_pkg::OP_ALLOC, 13'd8, 12'd0);
      send_request(ffac_pkg::OP_FREE, 13'd0, 12'd0);
      send_request(ffac_pkg::OP_FREE, 13'd0, 12'd0);
      send_request(ffac_pkg::OP_ALLOC, 13'd8, 12'd0);
      send_request(ffac_pkg::OP_ALLOC, 13'd16, 12'd0);
      send_request(ffac_pkg::OP_ALLOC, 13'd32, 12'd0);
      send_request(ffac_pkg::OP_FREE, 13'd0, 12'hff8);
      send_request(ffac_pkg::OP_FREE, 13'd0, 12'hfe8);
      send_request(ffac_pkg::OP_ALLOC, 13'd24, 12'd0);
      send_request(ffac_pkg::OP_FREE, 13'd0, 12'hfe0);
      send_request(ffac_pkg::OP_FREE, 13'd0, 12'hfc8);
      send_request(ffac_pkg::OP_ALLOC, 13'd4088, 12'd0);
      send_request(ffac_pkg::OP_FREE, 13'd0, 12'hff0);

      // pause until every response has come back
      wait_drained();

      random_phase(600);
      send_idle_pct = 75;
      recv_idle_pct = 31;
      random_phase(600);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(600);

      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
